// File: rtl/plane_point_bounding_box_macros.svh
// Assertion macros for the plane point bounding box block.
// Used by the queue, front and back modules; no other dependencies.
`ifndef PLANE_POINT_BOUNDING_BOX_MACROS_SVH
`define PLANE_POINT_BOUNDING_BOX_MACROS_SVH
`ifndef SYNTHESIS
`define PPBB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppbb assertion failed");
`define PPBB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppbb assertion failed");
`else
`define PPBB_ASSERT_IMPL(label, ante, cons)
`define PPBB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/ppbb_pkg.sv
// Shared types, constants and fixed-point helpers for the bounding box block.
// No dependencies.
package ppbb_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int NORM_W          = 16;
    localparam int Q_DEPTH         = 2;

    typedef enum logic [1:0] {
        REG_NORMAL_X,
        REG_NORMAL_Y,
        REG_NORMAL_Z,
        REG_PLANE_OFFSET
    } reg_idx_t;

    // One finished set, handed from front to back
    typedef struct packed {
        logic signed [31:0] min_v;
        logic signed [31:0] max_v;
        logic signed [31:0] min_w;
        logic signed [31:0] max_w;
        logic [2:0][15:0]   v;
        logic [2:0][15:0]   w;
        logic [2:0][15:0]   n;
        logic signed [31:0] d;
        logic               degen;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Drop 14 fraction bits, round half up
    function automatic logic signed [63:0] rnd14(input logic signed [63:0] x);
        return (x + 64'sd8192) >>> 14;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
        if (x > 64'sd32767)
            return 16'sh7fff;
        else if (x < -64'sd32768)
            return 16'sh8000;
        else
            return x[15:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

endpackage

// File: rtl/ppbb_queue.sv
// Two-entry request queue between front and back.
// Depends on ppbb_pkg and the assertion macro header.
`include "plane_point_bounding_box_macros.svh"
module ppbb_queue
    import ppbb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      push_data,
    input  logic      pop,
    output job_t      pop_data,
    output q_status_t status
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    job_t          mem [Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    assign pop_data     = mem[rd_ptr_reg];
    assign status.full  = (count_reg == (PW+1)'(Q_DEPTH));
    assign status.empty = (count_reg == '0);

    `PPBB_ASSERT_IMPL(a_no_overflow, push, !status.full)
    `PPBB_ASSERT_IMPL(a_no_underflow, pop, !status.empty)
    `PPBB_ASSERT_NEXT(a_push_fills, push && !pop, !status.empty)

endmodule

// File: rtl/ppbb_front.sv
// Front end: config registers, axis derivation, projection and min/max tracking.
// Depends on ppbb_pkg and the assertion macro header; feeds ppbb_queue.
`include "plane_point_bounding_box_macros.svh"
module ppbb_front
    import ppbb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic                          last_point,
    input  q_status_t                     q_status,
    output logic                          push,
    output job_t                          job
);

    typedef enum logic [4:0] {
        F_IDLE, F_Z0, F_Z1, F_Z2, F_S0, F_S1, F_S2, F_S3, F_CHK, F_SQRT,
        F_DIVI, F_DIV, F_DIVE, F_C0, F_C1, F_C2, F_C3, F_C4, F_C5, F_C6,
        F_DOT, F_DOTE, F_UPD, F_PUSH
    } state_t;

    state_t state_reg;

    logic signed [NORM_W-1:0]      nx_reg, ny_reg, nz_reg;
    logic signed [COORD_WIDTH-1:0] d_reg;
    logic signed [COORD_WIDTH-1:0] p_reg [3];
    logic                          last_reg;
    logic                          first_reg;
    logic                          degen_reg;
    logic signed [31:0]            zp_reg [3];
    logic [63:0]                   ssum_reg;
    logic [63:0]                   sq_s_reg, sq_r_reg, sq_bit_reg;
    logic [32:0]                   rem_reg;
    logic [45:0]                   quo_reg;
    logic [5:0]                    cnt_reg;
    logic [1:0]                    div_idx_reg;
    logic signed [15:0]            v_reg [3];
    logic signed [15:0]            w_reg [3];
    logic signed [63:0]            t_reg;
    logic signed [63:0]            prod_reg;
    logic signed [63:0]            acc_reg;
    logic [1:0]                    dot_k_reg;
    logic                          dot_sel_reg;
    logic signed [31:0]            pv_reg, pw_reg;
    logic signed [31:0]            min_v_reg, max_v_reg, min_w_reg, max_w_reg;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic [31:0]        len_w;
    logic [31:0]        zp_abs [3];
    logic [45:0]        div_num;
    logic [32:0]        rem_t;
    logic               rem_ge;
    logic [63:0]        sq_trial;
    logic signed [15:0] dot_axis;
    logic signed [31:0] dot_pt;
    logic signed [31:0] dot_res;
    logic signed [63:0] cross_w;
    logic signed [63:0] q_signed;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            zp_abs[i] = zp_reg[i][31] ? 32'(-zp_reg[i]) : 32'(zp_reg[i]);
    end

    assign len_w    = sq_r_reg[31:0];
    assign div_num  = (46'(zp_abs[div_idx_reg]) << 14) + 46'(len_w >> 1);
    assign rem_t    = {rem_reg[31:0], quo_reg[45]};
    assign rem_ge   = rem_t >= {1'b0, len_w};
    assign sq_trial = sq_r_reg + sq_bit_reg;
    assign cross_w  = rnd14(t_reg - prod_reg);
    assign dot_res  = sat32(rnd14(acc_reg));
    assign q_signed = zp_reg[div_idx_reg][31] ? -64'(quo_reg) : 64'(quo_reg);

    always_comb
    begin
        if (dot_k_reg == 2'd3)
        begin
            dot_axis = '0;
            dot_pt   = '0;
        end
        else
        begin
            dot_axis = dot_sel_reg ? w_reg[dot_k_reg] : v_reg[dot_k_reg];
            dot_pt   = 32'(p_reg[dot_k_reg]);
        end
    end

    // Shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            F_Z0:    begin mul_a = 32'(nx_reg);    mul_b = 32'(nz_reg);    end
            F_Z1:    begin mul_a = 32'(ny_reg);    mul_b = 32'(nz_reg);    end
            F_Z2:    begin mul_a = 32'(nz_reg);    mul_b = 32'(nz_reg);    end
            F_S0:    begin mul_a = zp_abs[0];      mul_b = zp_abs[0];      end
            F_S1:    begin mul_a = zp_abs[1];      mul_b = zp_abs[1];      end
            F_S2:    begin mul_a = zp_abs[2];      mul_b = zp_abs[2];      end
            F_C0:    begin mul_a = 32'(ny_reg);    mul_b = 32'(v_reg[2]);  end
            F_C1:    begin mul_a = 32'(nz_reg);    mul_b = 32'(v_reg[1]);  end
            F_C2:    begin mul_a = 32'(nz_reg);    mul_b = 32'(v_reg[0]);  end
            F_C3:    begin mul_a = 32'(nx_reg);    mul_b = 32'(v_reg[2]);  end
            F_C4:    begin mul_a = 32'(nx_reg);    mul_b = 32'(v_reg[1]);  end
            F_C5:    begin mul_a = 32'(ny_reg);    mul_b = 32'(v_reg[0]);  end
            F_DOT:   begin mul_a = 32'(dot_axis);  mul_b = dot_pt;         end
            default: begin mul_a = '0;             mul_b = '0;             end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            nx_reg      <= '0;
            ny_reg      <= '0;
            nz_reg      <= '0;
            d_reg       <= '0;
            first_reg   <= 1'b1;
            degen_reg   <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                v_reg[i] <= '0;
                w_reg[i] <= '0;
            end
            div_idx_reg <= '0;
            dot_k_reg   <= '0;
            dot_sel_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            prod_reg <= mul_p;

            if (cfg_write)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_NORMAL_X:     nx_reg <= cfg_data[NORM_W-1:0];
                    REG_NORMAL_Y:     ny_reg <= cfg_data[NORM_W-1:0];
                    REG_NORMAL_Z:     nz_reg <= cfg_data[NORM_W-1:0];
                    REG_PLANE_OFFSET: d_reg  <= cfg_data;
                endcase
            end

            unique case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        p_reg[0]    <= point_x;
                        p_reg[1]    <= point_y;
                        p_reg[2]    <= point_z;
                        last_reg    <= last_point;
                        dot_k_reg   <= '0;
                        dot_sel_reg <= 1'b0;
                        state_reg   <= first_reg ? F_Z0 : F_DOT;
                    end
                end
                F_Z0: state_reg <= F_Z1;
                F_Z1:
                begin
                    zp_reg[0] <= -prod_reg[31:0];
                    state_reg <= F_Z2;
                end
                F_Z2:
                begin
                    zp_reg[1] <= -prod_reg[31:0];
                    state_reg <= F_S0;
                end
                F_S0:
                begin
                    zp_reg[2] <= 32'sh10000000 - prod_reg[31:0];
                    state_reg <= F_S1;
                end
                F_S1:
                begin
                    ssum_reg  <= 64'(prod_reg);
                    state_reg <= F_S2;
                end
                F_S2:
                begin
                    ssum_reg  <= ssum_reg + 64'(prod_reg);
                    state_reg <= F_S3;
                end
                F_S3:
                begin
                    ssum_reg  <= ssum_reg + 64'(prod_reg);
                    state_reg <= F_CHK;
                end
                F_CHK:
                begin
                    if (ssum_reg == '0)
                    begin
                        degen_reg <= 1'b1;
                        for (int i = 0; i < 3; i++)
                        begin
                            v_reg[i] <= '0;
                            w_reg[i] <= '0;
                        end
                        state_reg <= F_DOT;
                    end
                    else
                    begin
                        degen_reg  <= 1'b0;
                        sq_s_reg   <= ssum_reg;
                        sq_r_reg   <= '0;
                        sq_bit_reg <= 64'd1 << 62;
                        state_reg  <= F_SQRT;
                    end
                end
                F_SQRT:
                begin
                    if (sq_s_reg >= sq_trial)
                    begin
                        sq_s_reg <= sq_s_reg - sq_trial;
                        sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                    end
                    else
                        sq_r_reg <= sq_r_reg >> 1;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg == 64'd1)
                    begin
                        div_idx_reg <= '0;
                        state_reg   <= F_DIVI;
                    end
                end
                F_DIVI:
                begin
                    rem_reg   <= '0;
                    quo_reg   <= div_num;
                    cnt_reg   <= 6'd45;
                    state_reg <= F_DIV;
                end
                F_DIV:
                begin
                    rem_reg <= rem_ge ? rem_t - {1'b0, len_w} : rem_t;
                    quo_reg <= {quo_reg[44:0], rem_ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= F_DIVE;
                end
                F_DIVE:
                begin
                    v_reg[div_idx_reg] <= sat16(q_signed);
                    if (div_idx_reg == 2'd2)
                        state_reg <= F_C0;
                    else
                    begin
                        div_idx_reg <= div_idx_reg + 1'b1;
                        state_reg   <= F_DIVI;
                    end
                end
                F_C0: state_reg <= F_C1;
                F_C1:
                begin
                    t_reg     <= prod_reg;
                    state_reg <= F_C2;
                end
                F_C2:
                begin
                    w_reg[0]  <= sat16(cross_w);
                    state_reg <= F_C3;
                end
                F_C3:
                begin
                    t_reg     <= prod_reg;
                    state_reg <= F_C4;
                end
                F_C4:
                begin
                    w_reg[1]  <= sat16(cross_w);
                    state_reg <= F_C5;
                end
                F_C5:
                begin
                    t_reg     <= prod_reg;
                    state_reg <= F_C6;
                end
                F_C6:
                begin
                    w_reg[2]  <= sat16(cross_w);
                    state_reg <= F_DOT;
                end
                F_DOT:
                begin
                    if (dot_k_reg == 2'd1)
                        acc_reg <= prod_reg;
                    else if (dot_k_reg != 2'd0)
                        acc_reg <= acc_reg + prod_reg;
                    dot_k_reg <= dot_k_reg + 1'b1;
                    if (dot_k_reg == 2'd3)
                        state_reg <= F_DOTE;
                end
                F_DOTE:
                begin
                    dot_k_reg <= '0;
                    if (!dot_sel_reg)
                    begin
                        pv_reg      <= dot_res;
                        dot_sel_reg <= 1'b1;
                        state_reg   <= F_DOT;
                    end
                    else
                    begin
                        pw_reg    <= dot_res;
                        state_reg <= F_UPD;
                    end
                end
                F_UPD:
                begin
                    if (first_reg)
                    begin
                        min_v_reg <= pv_reg;
                        max_v_reg <= pv_reg;
                        min_w_reg <= pw_reg;
                        max_w_reg <= pw_reg;
                    end
                    else
                    begin
                        if (pv_reg < min_v_reg) min_v_reg <= pv_reg;
                        if (pv_reg > max_v_reg) max_v_reg <= pv_reg;
                        if (pw_reg < min_w_reg) min_w_reg <= pw_reg;
                        if (pw_reg > max_w_reg) max_w_reg <= pw_reg;
                    end
                    first_reg <= last_reg;
                    state_reg <= last_reg ? F_PUSH : F_IDLE;
                end
                F_PUSH:
                begin
                    if (!q_status.full)
                        state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    assign in_stall = (state_reg != F_IDLE);
    assign push     = (state_reg == F_PUSH) && !q_status.full;

    assign job.min_v = min_v_reg;
    assign job.max_v = max_v_reg;
    assign job.min_w = min_w_reg;
    assign job.max_w = max_w_reg;
    assign job.v     = {v_reg[2], v_reg[1], v_reg[0]};
    assign job.w     = {w_reg[2], w_reg[1], w_reg[0]};
    assign job.n     = {nz_reg, ny_reg, nx_reg};
    assign job.d     = 32'(d_reg);
    assign job.degen = degen_reg;

    `PPBB_ASSERT_IMPL(a_push_ends_set, push, first_reg && last_reg)

endmodule

// File: rtl/ppbb_back.sv
// Back end: forms the four corners of a finished set and drives the output register.
// Depends on ppbb_pkg and the assertion macro header; reads from ppbb_queue.
`include "plane_point_bounding_box_macros.svh"
module ppbb_back
    import ppbb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  q_status_t                     q_status,
    input  job_t                          q_data,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] corner_x,
    output logic signed [COORD_WIDTH-1:0] corner_y,
    output logic signed [COORD_WIDTH-1:0] corner_z,
    output logic [1:0]                    corner_index,
    output logic                          degenerate,
    output logic                          last_corner
);

    typedef enum logic [2:0] {
        B_IDLE, B_M0, B_M1, B_M2, B_M3, B_RND, B_OUT
    } state_t;

    localparam logic signed [63:0] C_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] C_LO = -C_HI - 64'sd1;

    state_t                        state_reg;
    job_t                          job_reg;
    logic [1:0]                    k_reg;
    logic [1:0]                    i_reg;
    logic signed [63:0]            prod_reg;
    logic signed [63:0]            acc_reg;
    logic signed [COORD_WIDTH-1:0] comp_reg [3];
    logic                          out_valid_reg;
    logic signed [COORD_WIDTH-1:0] corner_x_reg, corner_y_reg, corner_z_reg;
    logic [1:0]                    corner_index_reg;
    logic                          degenerate_reg;
    logic                          last_corner_reg;

    logic signed [31:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [63:0] acc_rnd;
    logic signed [COORD_WIDTH-1:0] acc_sat;
    logic signed [31:0] u_sel, s_sel;
    logic               out_free;
    logic               corners_zero;

    assign u_sel = (k_reg == 2'd1 || k_reg == 2'd2) ? job_reg.max_v : job_reg.min_v;
    assign s_sel = (k_reg == 2'd1 || k_reg == 2'd3) ? job_reg.max_w : job_reg.min_w;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            B_M0:    begin mul_a = job_reg.d; mul_b = job_reg.n[i_reg]; end
            B_M1:    begin mul_a = u_sel;     mul_b = job_reg.v[i_reg]; end
            B_M2:    begin mul_a = s_sel;     mul_b = job_reg.w[i_reg]; end
            default: begin mul_a = '0;        mul_b = '0;               end
        endcase
    end

    assign acc_rnd = rnd14(acc_reg);

    always_comb
    begin
        if (acc_rnd > C_HI)
            acc_sat = COORD_WIDTH'(C_HI);
        else if (acc_rnd < C_LO)
            acc_sat = COORD_WIDTH'(C_LO);
        else
            acc_sat = acc_rnd[COORD_WIDTH-1:0];
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = (state_reg == B_IDLE) && !q_status.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            k_reg         <= '0;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prod_reg <= 64'(mul_a) * 64'(mul_b);
            if (state_reg == B_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_status.empty)
                    begin
                        job_reg   <= q_data;
                        k_reg     <= '0;
                        i_reg     <= '0;
                        state_reg <= B_M0;
                    end
                end
                B_M0: state_reg <= B_M1;
                B_M1:
                begin
                    acc_reg   <= -prod_reg;
                    state_reg <= B_M2;
                end
                B_M2:
                begin
                    acc_reg   <= acc_reg + prod_reg;
                    state_reg <= B_M3;
                end
                B_M3:
                begin
                    acc_reg   <= acc_reg + prod_reg;
                    state_reg <= B_RND;
                end
                B_RND:
                begin
                    comp_reg[i_reg] <= job_reg.degen ? '0 : acc_sat;
                    if (i_reg == 2'd2)
                    begin
                        i_reg     <= '0;
                        state_reg <= B_OUT;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= B_M0;
                    end
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        corner_x_reg     <= comp_reg[0];
                        corner_y_reg     <= comp_reg[1];
                        corner_z_reg     <= comp_reg[2];
                        corner_index_reg <= k_reg;
                        degenerate_reg   <= job_reg.degen;
                        last_corner_reg  <= (k_reg == 2'd3);
                        k_reg            <= k_reg + 1'b1;
                        state_reg        <= (k_reg == 2'd3) ? B_IDLE : B_M0;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign corner_x     = corner_x_reg;
    assign corner_y     = corner_y_reg;
    assign corner_z     = corner_z_reg;
    assign corner_index = corner_index_reg;
    assign degenerate   = degenerate_reg;
    assign last_corner  = last_corner_reg;

    assign corners_zero = (corner_x_reg == '0) && (corner_y_reg == '0) && (corner_z_reg == '0);

    `PPBB_ASSERT_IMPL(a_degen_zero, out_valid_reg && degenerate_reg, corners_zero)

endmodule

// File: rtl/plane_point_bounding_box.sv
// Top level of the plane point bounding box block: front, request queue and back.
// Depends on ppbb_pkg, ppbb_front, ppbb_queue and ppbb_back.
//
// Points of a set are taken one at a time: the front stalls the next point while
// its shared multiplier forms the two three-term projections. The first point of a
// set also waits for the axis derivation: a 32-step square root and three 46-step
// restoring divisions. On the point marked last, the finished set goes into a
// two-deep queue; the back end forms the four corners on its own multiplier, while
// the front already takes the next set unless the queue is full. Corners leave
// through an output register.
module plane_point_bounding_box
    import ppbb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic                          last_point,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] corner_x,
    output logic signed [COORD_WIDTH-1:0] corner_y,
    output logic signed [COORD_WIDTH-1:0] corner_z,
    output logic [1:0]                    corner_index,
    output logic                          degenerate,
    output logic                          last_corner
);

    q_status_t q_status;
    job_t      push_job;
    job_t      pop_job;
    logic      push;
    logic      pop;

    ppbb_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .last_point (last_point),
        .q_status   (q_status),
        .push       (push),
        .job        (push_job)
    );

    ppbb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .pop       (pop),
        .pop_data  (pop_job),
        .status    (q_status)
    );

    ppbb_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .q_data       (pop_job),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .corner_x     (corner_x),
        .corner_y     (corner_y),
        .corner_z     (corner_z),
        .corner_index (corner_index),
        .degenerate   (degenerate),
        .last_corner  (last_corner)
    );

endmodule

// File: tb/plane_point_bounding_box_test.sv
// Self-checking bench for plane_point_bounding_box: streams point sets under several
// plane settings, predicts the four corners of each set and checks them in order.
// Depends on ppbb_pkg and the plane_point_bounding_box RTL.
module plane_point_bounding_box_test;
    import ppbb_pkg::*;

    localparam int CW = 24;
    localparam longint CYCLE_LIMIT = 1000000;

    typedef struct {
        logic signed [CW-1:0] x, y, z;
        logic                 last;
    } point_t;

    typedef struct {
        logic signed [CW-1:0] x, y, z;
        logic [1:0]           idx;
        logic                 dg;
        logic                 lc;
    } corner_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [1:0]           cfg_index;
    logic [CW-1:0]        cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [CW-1:0] point_x, point_y, point_z;
    logic                 last_point;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [CW-1:0] corner_x, corner_y, corner_z;
    logic [1:0]           corner_index;
    logic                 degenerate;
    logic                 last_corner;

    point_t  pending_points[$];
    corner_t expected_corners[$];
    int      mismatches;
    int      items_sent;
    int      send_gap;
    int      hold_cnt;
    longint  cycles = 0;
    bit      quiet;

    // shadow registers and predictor state
    longint nrm[3];
    longint offset_d;
    longint ax_v[3], ax_w[3];
    longint min_v, max_v, min_w, max_w;
    bit     new_set;
    bit     axes_flat;

    plane_point_bounding_box u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .point_x(point_x), .point_y(point_y), .point_z(point_z), .last_point(last_point),
        .out_valid(out_valid), .out_stall(out_stall),
        .corner_x(corner_x), .corner_y(corner_y), .corner_z(corner_z),
        .corner_index(corner_index), .degenerate(degenerate), .last_corner(last_corner)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint clamp(longint x, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        return x > hi ? hi : (x < -hi - 1 ? -hi - 1 : x);
    endfunction

    function automatic longint drop14(longint x);
        return (x + 8192) >>> 14;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic derive_plane_axes();
        longint          zp[3];
        longint unsigned m, s, len, q;
        s = 0;
        zp[0] = -nrm[0] * nrm[2];
        zp[1] = -nrm[1] * nrm[2];
        zp[2] = (longint'(1) <<< 28) - nrm[2] * nrm[2];
        for (int i = 0; i < 3; i++)
        begin
            m = zp[i] < 0 ? -zp[i] : zp[i];
            s += m * m;
        end
        axes_flat = (s == 0);
        for (int i = 0; i < 3; i++)
        begin
            ax_v[i] = 0;
            ax_w[i] = 0;
        end
        if (!axes_flat)
        begin
            len = int_sqrt(s);
            for (int i = 0; i < 3; i++)
            begin
                m = zp[i] < 0 ? -zp[i] : zp[i];
                q = ((m << 14) + len / 2) / len;
                ax_v[i] = clamp(zp[i] < 0 ? -longint'(q) : longint'(q), 16);
            end
            ax_w[0] = clamp(drop14(nrm[1] * ax_v[2] - nrm[2] * ax_v[1]), 16);
            ax_w[1] = clamp(drop14(nrm[2] * ax_v[0] - nrm[0] * ax_v[2]), 16);
            ax_w[2] = clamp(drop14(nrm[0] * ax_v[1] - nrm[1] * ax_v[0]), 16);
        end
    endtask

    task automatic predict_corners(point_t p);
        longint  pt[3];
        longint  pv, pw, u, s;
        corner_t c;
        pt[0] = p.x;
        pt[1] = p.y;
        pt[2] = p.z;
        if (new_set)
            derive_plane_axes();
        pv = clamp(drop14(ax_v[0] * pt[0] + ax_v[1] * pt[1] + ax_v[2] * pt[2]), 32);
        pw = clamp(drop14(ax_w[0] * pt[0] + ax_w[1] * pt[1] + ax_w[2] * pt[2]), 32);
        if (new_set)
        begin
            min_v = pv;
            max_v = pv;
            min_w = pw;
            max_w = pw;
            new_set = 1'b0;
        end
        else
        begin
            if (pv < min_v) min_v = pv;
            if (pv > max_v) max_v = pv;
            if (pw < min_w) min_w = pw;
            if (pw > max_w) max_w = pw;
        end
        if (p.last)
        begin
            new_set = 1'b1;
            for (int k = 0; k < 4; k++)
            begin
                u = (k == 1 || k == 2) ? max_v : min_v;
                s = (k == 1 || k == 3) ? max_w : min_w;
                c.x = axes_flat ? 0 : clamp(drop14(-offset_d * nrm[0] + u * ax_v[0] + s * ax_w[0]), CW);
                c.y = axes_flat ? 0 : clamp(drop14(-offset_d * nrm[1] + u * ax_v[1] + s * ax_w[1]), CW);
                c.z = axes_flat ? 0 : clamp(drop14(-offset_d * nrm[2] + u * ax_v[2] + s * ax_w[2]), CW);
                c.idx = k;
                c.dg = axes_flat;
                c.lc = (k == 3);
                expected_corners.push_back(c);
            end
        end
    endtask

    task automatic report_mismatch(string what);
        mismatches++;
        $display("mismatch: %s", what);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        point_t p;
        bit     holding;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            point_x    <= '0;
            point_y    <= '0;
            point_z    <= '0;
            last_point <= 1'b0;
            send_gap   <= 0;
        end
        else
        begin
            holding = in_valid && in_stall;
            if (in_valid && !in_stall)
            begin
                p.x = point_x;
                p.y = point_y;
                p.z = point_z;
                p.last = last_point;
                predict_corners(p);
            end
            if (!holding)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_points.size() > 0)
                begin
                    p = pending_points.pop_front();
                    point_x    <= p.x;
                    point_y    <= p.y;
                    point_z    <= p.z;
                    last_point <= p.last;
                    in_valid   <= 1'b1;
                    send_gap   <= quiet ? 0 : $urandom_range(0, 8);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        corner_t e;
        int      n;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_cnt  <= 0;
        end
        else
        begin
            n = hold_cnt;
            if (out_valid && !out_stall)
            begin
                if (expected_corners.size() == 0)
                    report_mismatch("corner with none expected");
                else
                begin
                    e = expected_corners.pop_front();
                    if (corner_x !== e.x)
                        report_mismatch($sformatf("corner_x %0d want %0d", corner_x, e.x));
                    if (corner_y !== e.y)
                        report_mismatch($sformatf("corner_y %0d want %0d", corner_y, e.y));
                    if (corner_z !== e.z)
                        report_mismatch($sformatf("corner_z %0d want %0d", corner_z, e.z));
                    if (corner_index !== e.idx)
                        report_mismatch($sformatf("corner_index %0d want %0d", corner_index, e.idx));
                    if (degenerate !== e.dg)
                        report_mismatch($sformatf("degenerate %0b want %0b", degenerate, e.dg));
                    if (last_corner !== e.lc)
                        report_mismatch($sformatf("last_corner %0b want %0b", last_corner, e.lc));
                end
                n = quiet ? 0 : $urandom_range(0, 8);
            end
            else if (n > 0)
                n--;
            hold_cnt  <= n;
            out_stall <= (n != 0);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("plane_point_bounding_box verification failed");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, longint value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CW'(value);
        case (idx)
            REG_NORMAL_X:     nrm[0] = clamp(value, 16);
            REG_NORMAL_Y:     nrm[1] = clamp(value, 16);
            REG_NORMAL_Z:     nrm[2] = clamp(value, 16);
            REG_PLANE_OFFSET: offset_d = clamp(value, CW);
        endcase
    endtask

    task automatic set_plane(longint a, longint b, longint c, longint d);
        write_reg(REG_NORMAL_X, a);
        write_reg(REG_NORMAL_Y, b);
        write_reg(REG_NORMAL_Z, c);
        write_reg(REG_PLANE_OFFSET, d);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_point(longint x, longint y, longint z, bit last);
        point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.last = last;
        pending_points.push_back(p);
        items_sent++;
    endtask

    function automatic longint rand_coord();
        if ($urandom_range(0, 3) == 0)
            return clamp(longint'(signed'(CW'($urandom))), CW);
        return longint'($urandom_range(0, 1 << 18)) - (1 << 17);
    endfunction

    function automatic longint rand_normal();
        case ($urandom_range(0, 3))
            0:       return longint'(signed'(16'($urandom)));
            1:       return 0;
            default: return longint'($urandom_range(0, 32768)) - 16384;
        endcase
    endfunction

    // wait for all corners, then let the front settle before touching registers
    task automatic drain();
        do
            @(negedge clk);
        while (!(pending_points.size() == 0 && !in_valid && expected_corners.size() == 0));
        repeat (400) @(posedge clk);
    endtask

    initial
    begin
        int len;
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = REG_NORMAL_X;
        cfg_data   = '0;
        mismatches = 0;
        items_sent = 0;
        cycles     = 0;
        quiet      = 1'b0;
        new_set    = 1'b1;
        axes_flat  = 1'b0;
        offset_d   = 0;
        for (int i = 0; i < 3; i++)
        begin
            nrm[i] = 0;
            ax_v[i] = 0;
            ax_w[i] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n = 1'b1;

        // zero normal at reset values, single point set
        send_point(12345, -6789, 1000, 1'b1);
        drain();
        // normal straight along z: flat axis, corners forced to zero
        set_plane(16384, 0, 0, 0);
        set_plane(0, 0, 16384, 65536);
        send_point(65536, 65536, 0, 1'b0);
        send_point(-65536, 0, 0, 1'b1);
        drain();
        set_plane(0, 0, -16384, -65536);
        send_point(1, 2, 3, 1'b1);
        drain();
        // axis-aligned and tilted planes, tied projections and field extremes
        set_plane(16384, 0, 0, 131072);
        send_point(8388607, 8388607, 8388607, 1'b0);
        send_point(-8388608, -8388608, -8388608, 1'b0);
        send_point(8388607, 8388607, 8388607, 1'b0);
        send_point(0, 0, 0, 1'b1);
        drain();
        set_plane(-32768, -32768, -32768, -8388608);
        send_point(-8388608, 8388607, -8388608, 1'b0);
        send_point(8388607, -8388608, 8388607, 1'b1);
        send_point(5, 5, 5, 1'b1);
        drain();
        set_plane(32767, 32767, 32767, 8388607);
        send_point(8388607, 0, -8388608, 1'b0);
        send_point(0, 0, 0, 1'b0);
        send_point(0, 0, 0, 1'b1);
        drain();

        while (items_sent < 260)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            set_plane(rand_normal(), rand_normal(), rand_normal(),
                      $urandom_range(0, 3) == 0 ? clamp(longint'(signed'(CW'($urandom))), CW)
                                                : longint'($urandom_range(0, 1 << 20)) - (1 << 19));
            repeat ($urandom_range(3, 6))
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_point(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
            end
            drain();
        end

        if (mismatches == 0)
            $display("plane_point_bounding_box verification clean");
        else
            $display("plane_point_bounding_box verification failed");
        $finish;
    end

endmodule
